FILE: rtl/core/pidswc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pidswc_pkg
// Shared widths, register indexes, unit status type and saturation helper
// for the PID servo core.
// ----------------------------------------------------------------------------
package pidswc_pkg;

  localparam int unsigned DataW = 16;   // samples, gains, drive
  localparam int unsigned LimW  = 15;   // windup limit and divisor
  localparam int unsigned ProdW = 32;   // one signed gain product
  localparam int unsigned AccW  = 34;   // sum of three products plus headroom
  localparam int unsigned QuoW  = 32;   // magnitude of the sum
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_P_GAIN       = 3'd0,
    REG_I_GAIN       = 3'd1,
    REG_D_GAIN       = 3'd2,
    REG_WINDUP_LIMIT = 3'd3,
    REG_OUT_CENTRE   = 3'd4,
    REG_OUT_DIVISOR  = 3'd5,
    REG_OUT_LOW      = 3'd6,
    REG_OUT_HIGH     = 3'd7
  } cfg_reg_t;

  localparam logic CMD_RUN     = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  // status of a serial unit
  typedef struct packed {
    logic busy;
    logic done;   // one-cycle pulse, result valid from then on
  } unit_sts_t;

  localparam logic signed [AccW-1:0] SatMax = 34'sd32767;
  localparam logic signed [AccW-1:0] SatMin = -34'sd32768;

  function automatic logic signed [DataW-1:0] sat16(input logic signed [AccW-1:0] v);
    logic signed [DataW-1:0] r;
    if (v > SatMax) begin
      r = 16'sh7fff;
    end else if (v < SatMin) begin
      r = 16'sh8000;
    end else begin
      r = v[DataW-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/pidswc_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pidswc_mul
// Bit-serial signed 16x16 multiplier: shift-add on magnitudes, one
// multiplier bit per cycle, sign applied on the way out.
// ----------------------------------------------------------------------------
module pidswc_mul (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  input  wire logic signed [pidswc_pkg::DataW-1:0]  mcand,
  input  wire logic signed [pidswc_pkg::DataW-1:0]  mplier,
  output pidswc_pkg::unit_sts_t                     sts,
  output logic signed [pidswc_pkg::ProdW-1:0]       product
);
  import pidswc_pkg::*;

  logic [DataW-1:0]  a_mag_r, a_mag_nxt;
  logic              neg_r, neg_nxt;
  logic [ProdW-1:0]  p_r, p_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  logic [DataW-1:0]  mcand_mag, mplier_mag;
  logic [DataW:0]    part;
  logic [ProdW-1:0]  p_neg;

  assign mcand_mag  = mcand[DataW-1]  ? (~mcand  + 16'd1) : mcand;
  assign mplier_mag = mplier[DataW-1] ? (~mplier + 16'd1) : mplier;

  // add the multiplicand into the upper half when the low bit is set
  assign part = {1'b0, p_r[ProdW-1:DataW]} + (p_r[0] ? {1'b0, a_mag_r} : 17'd0);

  always_comb begin
    a_mag_nxt = a_mag_r;
    neg_nxt   = neg_r;
    p_nxt     = p_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (start) begin
      a_mag_nxt = mcand_mag;
      neg_nxt   = mcand[DataW-1] ^ mplier[DataW-1];
      p_nxt     = {16'd0, mplier_mag};
      cnt_nxt   = 5'd16;
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      p_nxt   = {part, p_r[DataW-1:1]};
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_mag_r <= a_mag_nxt;
    neg_r   <= neg_nxt;
    p_r     <= p_nxt;
  end

  assign p_neg   = ~p_r + 32'd1;
  assign product = neg_r ? $signed(p_neg) : $signed(p_r);
  assign sts     = '{busy: busy_r, done: done_r};

endmodule
`default_nettype wire

FILE: rtl/core/pidswc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pidswc_div
// Restoring divider, one quotient bit per cycle: 32-bit magnitude by a
// 15-bit divisor (zero divisor taken as one).
// ----------------------------------------------------------------------------
module pidswc_div (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic [pidswc_pkg::QuoW-1:0]       dividend,
  input  wire logic [pidswc_pkg::LimW-1:0]       divisor,
  output pidswc_pkg::unit_sts_t                  sts,
  output logic [pidswc_pkg::QuoW-1:0]            quotient
);
  import pidswc_pkg::*;

  logic [LimW-1:0]  dv_r, dv_nxt;
  logic [LimW-1:0]  rem_r, rem_nxt;
  logic [QuoW-1:0]  quo_r, quo_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  logic [LimW:0]    trial;
  logic [LimW+1:0]  diff;
  logic             ge;

  assign trial = {rem_r, quo_r[QuoW-1]};
  assign diff  = {1'b0, trial} - {2'b00, dv_r};
  assign ge    = ~diff[LimW+1];

  always_comb begin
    dv_nxt   = dv_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dv_nxt   = (divisor == '0) ? 15'd1 : divisor;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[LimW-1:0] : trial[LimW-1:0];
      quo_nxt = {quo_r[QuoW-2:0], ge};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dv_r  <= dv_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign quotient = quo_r;
  assign sts      = '{busy: busy_r, done: done_r};

endmodule
`default_nettype wire

FILE: rtl/core/pid_servo_windup_clip_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pid_servo_windup_clip_core
// Signed 16-bit PID servo with clipped error sum, scaled and clamped drive.
// Sequence: a run item passes three times through the bit-serial multiplier,
//   once through the divider, then is clamped into the output register once
//   the output slot is free.
// Flow: in_stall holds new items off until the last run item's drive is
//   registered; a restart item is taken while idle and gives no result.
// Reset: synchronous, active low; error sum and previous sample clear,
//   registers take their documented reset values, no result pending.
// ----------------------------------------------------------------------------
module pid_servo_windup_clip_core (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // input items
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic                                  in_cmd,
  input  wire logic signed [pidswc_pkg::DataW-1:0]   in_target,
  input  wire logic signed [pidswc_pkg::DataW-1:0]   in_measured,
  // result items
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [pidswc_pkg::DataW-1:0]        out_drive,
  // configuration writes
  input  wire logic                                  cfg_we,
  input  wire logic [pidswc_pkg::CfgIdxW-1:0]        cfg_index,
  input  wire logic [pidswc_pkg::DataW-1:0]          cfg_data
);
  import pidswc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [DataW-1:0] p_gain_r, i_gain_r, d_gain_r;
  logic [LimW-1:0]         windup_r, divisor_r;
  logic signed [DataW-1:0] centre_r, low_r, high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_gain_r  <= '0;
      i_gain_r  <= '0;
      d_gain_r  <= '0;
      windup_r  <= 15'h7fff;
      centre_r  <= '0;
      divisor_r <= 15'd1;
      low_r     <= 16'sh8000;
      high_r    <= 16'sh7fff;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_P_GAIN:       p_gain_r  <= cfg_data;
        REG_I_GAIN:       i_gain_r  <= cfg_data;
        REG_D_GAIN:       d_gain_r  <= cfg_data;
        REG_WINDUP_LIMIT: windup_r  <= cfg_data[LimW-1:0];
        REG_OUT_CENTRE:   centre_r  <= cfg_data;
        REG_OUT_DIVISOR:  divisor_r <= cfg_data[LimW-1:0];
        REG_OUT_LOW:      low_r     <= cfg_data;
        REG_OUT_HIGH:     high_r    <= cfg_data;
        default:          ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Loop state and sequencer registers
  // --------------------------------------------------------------------------
  state_t                  state_r, state_nxt;
  logic signed [DataW-1:0] es_r, es_nxt;         // clipped error sum
  logic signed [DataW-1:0] prev_r, prev_nxt;     // previous sample
  logic signed [DataW-1:0] pdiff_r, pdiff_nxt;
  logic signed [DataW-1:0] ddiff_r, ddiff_nxt;
  logic [1:0]              term_r, term_nxt;     // which gain product is running
  logic signed [AccW-1:0]  acc_r, acc_nxt;
  logic                    mul_start_r, mul_start_nxt;
  logic                    div_start_r, div_start_nxt;
  logic signed [DataW-1:0] pre_r, pre_nxt;       // centred, saturated drive
  logic                    out_valid_r, out_valid_nxt;
  logic signed [DataW-1:0] out_drive_r, out_drive_nxt;

  logic in_acc;
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // --------------------------------------------------------------------------
  // Per-item front end: error sum clip and the two saturated differences
  // --------------------------------------------------------------------------
  logic signed [17:0] es_raw, lim_pos, lim_neg, es_clip;
  logic signed [16:0] pd17, dd17;

  assign es_raw  = 18'(es_r) - 18'(in_measured);
  assign lim_pos = $signed({3'b000, windup_r});
  assign lim_neg = -lim_pos;
  always_comb begin
    priority if (es_raw > lim_pos) begin
      es_clip = lim_pos;
    end else if (es_raw < lim_neg) begin
      es_clip = lim_neg;
    end else begin
      es_clip = es_raw;
    end
  end

  assign pd17 = 17'(in_measured) - 17'(in_target);
  assign dd17 = 17'(in_measured) - 17'(prev_r);

  // --------------------------------------------------------------------------
  // Serial arithmetic units
  // --------------------------------------------------------------------------
  unit_sts_t               mul_sts, div_sts;
  logic signed [DataW-1:0] mul_gain, mul_val;
  logic signed [ProdW-1:0] mul_prod;
  logic signed [AccW-1:0]  acc_abs;
  logic [QuoW-1:0]         quo;

  always_comb begin
    unique case (term_r)
      2'd0:    begin mul_gain = p_gain_r; mul_val = pdiff_r; end
      2'd1:    begin mul_gain = i_gain_r; mul_val = es_r;    end
      default: begin mul_gain = d_gain_r; mul_val = ddiff_r; end
    endcase
  end

  pidswc_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start_r),
    .mcand   (mul_gain),
    .mplier  (mul_val),
    .sts     (mul_sts),
    .product (mul_prod)
  );

  // sum magnitude stays below 2^32, so the low word carries it whole
  assign acc_abs = acc_r[AccW-1] ? -acc_r : acc_r;

  pidswc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (acc_abs[QuoW-1:0]),
    .divisor  (divisor_r),
    .sts      (div_sts),
    .quotient (quo)
  );

  // quotient takes the sign of the sum (truncation toward zero), then centre
  logic signed [AccW-1:0] q_pos, q_sgn, centred;
  assign q_pos   = $signed({2'b00, quo});
  assign q_sgn   = acc_r[AccW-1] ? -q_pos : q_pos;
  assign centred = q_sgn + AccW'(centre_r);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    es_nxt        = es_r;
    prev_nxt      = prev_r;
    pdiff_nxt     = pdiff_r;
    ddiff_nxt     = ddiff_r;
    term_nxt      = term_r;
    acc_nxt       = acc_r;
    mul_start_nxt = 1'b0;
    div_start_nxt = 1'b0;
    pre_nxt       = pre_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_drive_nxt = out_drive_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_cmd == CMD_RESTART) begin
            es_nxt   = '0;
            prev_nxt = in_target;
          end else begin
            es_nxt        = es_clip[DataW-1:0];
            prev_nxt      = in_measured;
            pdiff_nxt     = sat16(AccW'(pd17));
            ddiff_nxt     = sat16(AccW'(dd17));
            term_nxt      = 2'd0;
            acc_nxt       = '0;
            mul_start_nxt = 1'b1;
            state_nxt     = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        if (mul_sts.done) begin
          acc_nxt = acc_r + AccW'(mul_prod);
          if (term_r == 2'd2) begin
            div_start_nxt = 1'b1;
            state_nxt     = ST_DIV;
          end else begin
            term_nxt      = term_r + 2'd1;
            mul_start_nxt = 1'b1;
          end
        end
      end
      ST_DIV: begin
        if (div_sts.done) begin
          pre_nxt   = sat16(centred);
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // wait for the output slot; when limits cross, a drive below low takes low, any other takes high
        if (!out_valid_r || !out_stall) begin
          priority if (pre_r < low_r) begin
            out_drive_nxt = low_r;
          end else if (pre_r > high_r) begin
            out_drive_nxt = high_r;
          end else begin
            out_drive_nxt = pre_r;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      es_r        <= '0;
      prev_r      <= '0;
      term_r      <= 2'd0;
      mul_start_r <= 1'b0;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      es_r        <= es_nxt;
      prev_r      <= prev_nxt;
      term_r      <= term_nxt;
      mul_start_r <= mul_start_nxt;
      div_start_r <= div_start_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pdiff_r     <= pdiff_nxt;
    ddiff_r     <= ddiff_nxt;
    acc_r       <= acc_nxt;
    pre_r       <= pre_nxt;
    out_drive_r <= out_drive_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_drive = out_drive_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef ASSERT_OFF
  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_sts.busy && div_sts.busy))
    else $error("multiplier and divider busy together");

  a_mul_in_mul_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_sts.done |-> state_r == ST_MUL)
    else $error("product finished outside the multiply phase");

  a_div_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |=> state_r == ST_FIN)
    else $error("quotient not taken into the finish phase");

  // a run item leaves the error sum inside the limit it was clipped to
  a_error_sum_clip: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_cmd == CMD_RUN) |=> (18'(es_r) <= lim_pos) && (18'(es_r) >= lim_neg))
    else $error("error sum outside the windup limit");

  a_drive_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (low_r <= high_r)) |-> (out_drive_r >= low_r && out_drive_r <= high_r))
    else $error("drive outside the output limits");
`endif

endmodule
`default_nettype wire
